### rtl/mmrc_pkg.sv
package mmrc_pkg;

    localparam int unsigned FRAME_LEN  = 25;
    localparam int unsigned CRC_SPAN   = 23;
    localparam int unsigned POS_W      = 5;
    localparam logic [7:0]  FUNC_READ_IN = 8'h04;
    localparam logic [7:0]  DATA_COUNT   = 8'd20;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FRAME_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;

    localparam logic REG_EXPECTED  = 1'b0;
    localparam logic REG_UNCHECKED = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_CRC_LO,
        KIND_LAST
    } kind_t;

    // One classified byte on its way from front to back
    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] pos;
        logic [7:0]       rx_byte;
    } entry_t;

    typedef struct packed {
        logic [7:0] expected_address;
        logic [7:0] unchecked_address;
    } cfg_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/mmrc_if.sv
interface mmrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mmrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] voltage_raw;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] frequency_raw;
    logic [15:0] power_factor_raw;
    logic [15:0] alarm_word;

    modport source (output valid, output status, output voltage_raw, output current_raw,
                    output power_raw, output energy_raw, output frequency_raw,
                    output power_factor_raw, output alarm_word, input ready);
    modport sink   (input valid, input status, input voltage_raw, input current_raw,
                    input power_raw, input energy_raw, input frequency_raw,
                    input power_factor_raw, input alarm_word, output ready);
endinterface

### rtl/mmrc_front.sv
module mmrc_front (
    input  logic            clk,
    input  logic            rst_n,
    mmrc_in_if.sink         in,
    output logic            push_valid,
    input  logic            push_ready,
    output mmrc_pkg::entry_t push_entry
);

    logic [mmrc_pkg::POS_W-1:0] pos_reg;
    logic [mmrc_pkg::POS_W-1:0] pos_next;
    logic [mmrc_pkg::POS_W-1:0] cur_pos;
    logic                       keep;
    logic                       accept;

    assign in.ready = push_ready;
    assign accept   = in.valid && in.ready;

    always_comb
    begin
        cur_pos = in.frame_start ? '0 : pos_reg;
        // drop bytes that arrive with no frame in progress
        keep    = in.frame_start || (pos_reg != '0);
        push_entry.pos     = cur_pos;
        push_entry.rx_byte = in.rx_byte;
        if (cur_pos == mmrc_pkg::POS_LAST)
            push_entry.kind = mmrc_pkg::KIND_LAST;
        else if (cur_pos == mmrc_pkg::POS_CRC_LO)
            push_entry.kind = mmrc_pkg::KIND_CRC_LO;
        else
            push_entry.kind = mmrc_pkg::KIND_DATA;

        if (!keep || cur_pos == mmrc_pkg::POS_LAST)
            pos_next = '0;
        else
            pos_next = cur_pos + 1'b1;
    end

    assign push_valid = in.valid && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mmrc_pkg::POS_LAST)
        else $error("byte position out of range");

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in.frame_start |=> pos_reg == 1)
        else $error("first byte did not restart the frame");

endmodule

### rtl/mmrc_queue.sv
module mmrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mmrc_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mmrc_pkg::entry_t pop_entry
);

    mmrc_pkg::entry_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

### rtl/mmrc_back.sv
module mmrc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mmrc_pkg::cfg_t   cfg,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mmrc_pkg::entry_t pop_entry,
    mmrc_out_if.source       out
);

    logic [15:0] crc_reg;
    logic [7:0]  crc_low_reg;
    logic [7:0]  frame_reg [mmrc_pkg::CRC_SPAN];
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [15:0] voltage_reg;
    logic [31:0] current_reg;
    logic [31:0] power_reg;
    logic [31:0] energy_reg;
    logic [15:0] frequency_reg;
    logic [15:0] pf_reg;
    logic [15:0] alarm_reg;

    logic        do_pop;
    logic        is_last;
    logic [15:0] crc_base;
    logic [15:0] rx_crc;
    logic        frame_bad;
    logic [1:0]  status_calc;
    logic        ok;

    assign pop_ready = !out_valid_reg || out.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign is_last   = (pop_entry.kind == mmrc_pkg::KIND_LAST);
    assign crc_base  = (pop_entry.pos == '0) ? mmrc_pkg::CRC_INIT : crc_reg;
    assign rx_crc    = {pop_entry.rx_byte, crc_low_reg};

    always_comb
    begin
        frame_bad = (frame_reg[1] != mmrc_pkg::FUNC_READ_IN) ||
                    (frame_reg[2] != mmrc_pkg::DATA_COUNT) ||
                    ((cfg.expected_address != cfg.unchecked_address) &&
                     (frame_reg[0] != cfg.expected_address));
        if (frame_bad)
            status_calc = mmrc_pkg::STATUS_FRAME_ERR;
        else if (crc_reg != rx_crc)
            status_calc = mmrc_pkg::STATUS_CRC_ERR;
        else
            status_calc = mmrc_pkg::STATUS_OK;
        ok = (status_calc == mmrc_pkg::STATUS_OK);

        out_valid_next = out_valid_reg;
        if (do_pop && is_last)
            out_valid_next = 1'b1;
        else if (out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= mmrc_pkg::CRC_INIT;
            crc_low_reg   <= 8'h00;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_pop && pop_entry.kind == mmrc_pkg::KIND_DATA)
                crc_reg <= mmrc_pkg::crc_feed(crc_base, pop_entry.rx_byte);
            if (do_pop && pop_entry.kind == mmrc_pkg::KIND_CRC_LO)
                crc_low_reg <= pop_entry.rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            unique case (pop_entry.kind)
                mmrc_pkg::KIND_DATA:
                begin
                    frame_reg[pop_entry.pos] <= pop_entry.rx_byte;
                end
                mmrc_pkg::KIND_CRC_LO:
                begin
                end
                mmrc_pkg::KIND_LAST:
                begin
                    // zero every reading on a failed frame
                    status_reg    <= status_calc;
                    voltage_reg   <= ok ? {frame_reg[3], frame_reg[4]} : 16'h0000;
                    current_reg   <= ok ? {frame_reg[7], frame_reg[8],
                                           frame_reg[5], frame_reg[6]} : 32'h0;
                    power_reg     <= ok ? {frame_reg[11], frame_reg[12],
                                           frame_reg[9], frame_reg[10]} : 32'h0;
                    energy_reg    <= ok ? {frame_reg[15], frame_reg[16],
                                           frame_reg[13], frame_reg[14]} : 32'h0;
                    frequency_reg <= ok ? {frame_reg[17], frame_reg[18]} : 16'h0000;
                    pf_reg        <= ok ? {frame_reg[19], frame_reg[20]} : 16'h0000;
                    alarm_reg     <= ok ? {frame_reg[21], frame_reg[22]} : 16'h0000;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out.valid            = out_valid_reg;
    assign out.status           = status_reg;
    assign out.voltage_raw      = voltage_reg;
    assign out.current_raw      = current_reg;
    assign out.power_raw        = power_reg;
    assign out.energy_raw       = energy_reg;
    assign out.frequency_raw    = frequency_reg;
    assign out.power_factor_raw = pf_reg;
    assign out.alarm_word       = alarm_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && is_last |=> out_valid_reg)
        else $error("completed frame produced no result");

    a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out.ready |-> !do_pop)
        else $error("item consumed while result is stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != mmrc_pkg::STATUS_OK |->
            voltage_reg == 16'h0 && current_reg == 32'h0 && alarm_reg == 16'h0)
        else $error("failed frame carries readings");

endmodule

### rtl/modbus_meter_response_checker_top.sv
// Modbus RTU read-input-registers response checker for a 25-byte energy meter
// frame. Feed received bytes one per beat and mark the first byte of each frame
// with frame_start; an unmarked byte with no frame open is dropped. The block
// takes one byte per cycle, every cycle, as long as results are taken; the
// front classifier, a two-entry queue and the back end (CRC-16 update, frame
// store and checks) each move one byte per cycle. One result beat follows the
// 25th byte and is held until taken. Status 0 is ok with readings, 1 is a
// frame error (function code, byte count or address), 2 is a CRC error;
// errors return zero readings. Write the address registers only while the
// block is idle.
module modbus_meter_response_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    mmrc_in_if.sink    in,
    mmrc_out_if.source out,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    mmrc_pkg::cfg_t   cfg_reg;
    logic             push_valid;
    logic             push_ready;
    mmrc_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    mmrc_pkg::entry_t pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_address  <= 8'd248;
            cfg_reg.unchecked_address <= 8'd248;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmrc_pkg::REG_EXPECTED:  cfg_reg.expected_address  <= cfg_data;
                mmrc_pkg::REG_UNCHECKED: cfg_reg.unchecked_address <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    mmrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    mmrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mmrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out       (out)
    );

endmodule
